// ----- rtl/etm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_pkg
// Shared types and constants of the Euler-angle TRS model matrix pipeline.
// ----------------------------------------------------------------------------
package etm_pkg;

  localparam int AtanLen = 24;

  localparam logic signed [33:0] KGain  = 34'sd652032874;
  localparam logic signed [33:0] Pi     = 34'sd3373259426;
  localparam logic signed [33:0] HalfPi = 34'sd1686629713;

  localparam logic signed [26:0] LinMax = 27'sd8388607;
  localparam logic signed [26:0] LinMin = -27'sd8388608;

  typedef logic signed [31:0] trig_val_t;
  typedef logic signed [32:0] rot_val_t;
  typedef logic signed [23:0] lin_val_t;

  typedef struct packed {
    trig_val_t sin;
    trig_val_t cos;
  } trig_t;

  typedef rot_val_t rot_t [9];
  typedef lin_val_t lin_t [9];

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'd843314856;
      1:  v = 32'd497837829;
      2:  v = 32'd263043836;
      3:  v = 32'd133525158;
      4:  v = 32'd67021686;
      5:  v = 32'd33543515;
      6:  v = 32'd16775850;
      7:  v = 32'd8388437;
      8:  v = 32'd4194282;
      9:  v = 32'd2097149;
      10: v = 32'd1048575;
      11: v = 32'd524287;
      12: v = 32'd262143;
      13: v = 32'd131071;
      14: v = 32'd65535;
      15: v = 32'd32767;
      16: v = 32'd16383;
      17: v = 32'd8191;
      18: v = 32'd4095;
      19: v = 32'd2047;
      20: v = 32'd1023;
      21: v = 32'd511;
      22: v = 32'd255;
      23: v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/etm_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_in_if
// Input channel: translation, Euler angles and scale of one transaction.
// ----------------------------------------------------------------------------
interface etm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] translate_x;
  logic signed [31:0] translate_y;
  logic signed [31:0] translate_z;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;
  logic signed [15:0] scale_x;
  logic signed [15:0] scale_y;
  logic signed [15:0] scale_z;

  modport source (output valid, translate_x, translate_y, translate_z,
                  angle_x, angle_y, angle_z, scale_x, scale_y, scale_z,
                  input ready);
  modport sink (input valid, translate_x, translate_y, translate_z,
                angle_x, angle_y, angle_z, scale_x, scale_y, scale_z,
                output ready);
endinterface

// ----- rtl/etm_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_out_if
// Output channel: top three rows of the model matrix.
// ----------------------------------------------------------------------------
interface etm_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] m00;
  logic signed [23:0] m01;
  logic signed [23:0] m02;
  logic signed [31:0] m03;
  logic signed [23:0] m10;
  logic signed [23:0] m11;
  logic signed [23:0] m12;
  logic signed [31:0] m13;
  logic signed [23:0] m20;
  logic signed [23:0] m21;
  logic signed [23:0] m22;
  logic signed [31:0] m23;

  modport source (output valid, m00, m01, m02, m03, m10, m11, m12, m13,
                  m20, m21, m22, m23, input ready);
  modport sink (input valid, m00, m01, m02, m03, m10, m11, m12, m13,
                m20, m21, m22, m23, output ready);
endinterface

// ----- rtl/etm_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_cordic
// Range reduction register followed by one register stage per CORDIC step.
// ----------------------------------------------------------------------------
module etm_cordic #(
  parameter int STAGES = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] angle_i,
  output etm_pkg::trig_t     trig_o
);
  import etm_pkg::*;

  logic signed [33:0] x_q [STAGES+1];
  logic signed [33:0] y_q [STAGES+1];
  logic signed [33:0] z_q [STAGES+1];
  logic               neg_q [STAGES+1];
  logic signed [33:0] z_in;

  assign z_in = {angle_i[15], angle_i, 17'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= KGain;
      y_q[0] <= '0;
      if (z_in > HalfPi) begin
        z_q[0]   <= z_in - Pi;
        neg_q[0] <= 1'b1;
      end else if (z_in < -HalfPi) begin
        z_q[0]   <= z_in + Pi;
        neg_q[0] <= 1'b1;
      end else begin
        z_q[0]   <= z_in;
        neg_q[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [33:0] Atan = 34'(atan_q30(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][33]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - Atan;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + Atan;
        end
        neg_q[i+1] <= neg_q[i];
      end
    end
  end

  assign trig_o.sin = neg_q[STAGES] ? 32'(-y_q[STAGES]) : 32'(y_q[STAGES]);
  assign trig_o.cos = neg_q[STAGES] ? 32'(-x_q[STAGES]) : 32'(x_q[STAGES]);

endmodule

// ----- rtl/etm_rotmat.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_rotmat
// Two register stages forming the rotation Rz*Ry*Rx from sines and cosines.
// ----------------------------------------------------------------------------
module etm_rotmat (
  input  logic           clk_i,
  input  logic           en_i,
  input  etm_pkg::trig_t trig_x_i,
  input  etm_pkg::trig_t trig_y_i,
  input  etm_pkg::trig_t trig_z_i,
  output etm_pkg::rot_t  rot_o
);
  import etm_pkg::*;

  function automatic trig_val_t mul30(input trig_val_t a, input trig_val_t b);
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    return 32'(p >>> 30);
  endfunction

  function automatic rot_val_t wid(input trig_val_t a);
    return 33'(a);
  endfunction

  trig_val_t czcy_q, czsy_q, szsy_q, szcx_q, szsx_q, czcx_q, czsx_q;
  trig_val_t cysx_q, cycx_q, szcy_q, sx_q, cx_q, sy_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      czcy_q <= mul30(trig_z_i.cos, trig_y_i.cos);
      czsy_q <= mul30(trig_z_i.cos, trig_y_i.sin);
      szsy_q <= mul30(trig_z_i.sin, trig_y_i.sin);
      szcx_q <= mul30(trig_z_i.sin, trig_x_i.cos);
      szsx_q <= mul30(trig_z_i.sin, trig_x_i.sin);
      czcx_q <= mul30(trig_z_i.cos, trig_x_i.cos);
      czsx_q <= mul30(trig_z_i.cos, trig_x_i.sin);
      cysx_q <= mul30(trig_y_i.cos, trig_x_i.sin);
      cycx_q <= mul30(trig_y_i.cos, trig_x_i.cos);
      szcy_q <= mul30(trig_z_i.sin, trig_y_i.cos);
      sx_q   <= trig_x_i.sin;
      cx_q   <= trig_x_i.cos;
      sy_q   <= trig_y_i.sin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_o[0] <= wid(czcy_q);
      rot_o[1] <= wid(mul30(czsy_q, sx_q)) + wid(szcx_q);
      rot_o[2] <= wid(szsx_q) - wid(mul30(czsy_q, cx_q));
      rot_o[3] <= -wid(szcy_q);
      rot_o[4] <= wid(czcx_q) - wid(mul30(szsy_q, sx_q));
      rot_o[5] <= wid(mul30(szsy_q, cx_q)) + wid(czsx_q);
      rot_o[6] <= wid(sy_q);
      rot_o[7] <= -wid(cysx_q);
      rot_o[8] <= wid(cycx_q);
    end
  end

endmodule

// ----- rtl/etm_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etm_scale
// Column scaling with rounding to Q8.16 and saturation, into the output register.
// ----------------------------------------------------------------------------
module etm_scale (
  input  logic               clk_i,
  input  logic               en_i,
  input  etm_pkg::rot_t      rot_i,
  input  logic signed [15:0] scale_x_i,
  input  logic signed [15:0] scale_y_i,
  input  logic signed [15:0] scale_z_i,
  output etm_pkg::lin_t      lin_o
);
  import etm_pkg::*;

  function automatic lin_val_t lin(input rot_val_t r, input logic signed [15:0] s);
    logic signed [48:0] p;
    logic signed [26:0] q;
    p = r * s + 49'sd2097152;
    q = 27'(p >>> 22);
    if (q > LinMax) begin
      q = LinMax;
    end else if (q < LinMin) begin
      q = LinMin;
    end
    return 24'(q);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        lin_o[3*r]     <= lin(rot_i[3*r],     scale_x_i);
        lin_o[3*r + 1] <= lin(rot_i[3*r + 1], scale_y_i);
        lin_o[3*r + 2] <= lin(rot_i[3*r + 2], scale_z_i);
      end
    end
  end

endmodule

// ----- rtl/euler_trs_model_matrix.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_trs_model_matrix
// Pipelined T*Rz*Ry*Rx*S model matrix builder with CORDIC sine and cosine.
//
//   channel | direction | content
//   in_i    | sink      | translation, three angles, three scales
//   out_o   | source    | rows 0..2 of the affine matrix
//
// One transaction per cycle while the output is not stalled; the stages are
// the range reduction register, one register per CORDIC step, two product
// stages and the scaling output register.
// Reset clears the valid bits only.
// A stalled output freezes the whole pipeline; in_i.ready is low only then.
// ----------------------------------------------------------------------------
module euler_trs_model_matrix #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  etm_in_if.sink     in_i,
  etm_out_if.source  out_o
);
  import etm_pkg::*;

  localparam int Lat = CORDIC_STAGES + 4;

  logic               adv;
  logic [Lat-1:0]     valid_q;
  logic signed [31:0] tr_q [Lat][3];
  logic signed [15:0] sc_q [Lat-1][3];
  trig_t              trig_x, trig_y, trig_z;
  rot_t               rot;
  lin_t               lin;

  assign adv        = !valid_q[Lat-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[Lat-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tr_q[0][0] <= in_i.translate_x;
      tr_q[0][1] <= in_i.translate_y;
      tr_q[0][2] <= in_i.translate_z;
      sc_q[0][0] <= in_i.scale_x;
      sc_q[0][1] <= in_i.scale_y;
      sc_q[0][2] <= in_i.scale_z;
      for (int i = 1; i < Lat; i++) begin
        tr_q[i] <= tr_q[i-1];
      end
      for (int i = 1; i < Lat - 1; i++) begin
        sc_q[i] <= sc_q[i-1];
      end
    end
  end

  etm_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_x (
    .clk_i, .en_i(adv), .angle_i(in_i.angle_x), .trig_o(trig_x)
  );
  etm_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_y (
    .clk_i, .en_i(adv), .angle_i(in_i.angle_y), .trig_o(trig_y)
  );
  etm_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_z (
    .clk_i, .en_i(adv), .angle_i(in_i.angle_z), .trig_o(trig_z)
  );

  etm_rotmat u_rotmat (
    .clk_i, .en_i(adv), .trig_x_i(trig_x), .trig_y_i(trig_y),
    .trig_z_i(trig_z), .rot_o(rot)
  );

  etm_scale u_scale (
    .clk_i, .en_i(adv), .rot_i(rot),
    .scale_x_i(sc_q[Lat-2][0]), .scale_y_i(sc_q[Lat-2][1]),
    .scale_z_i(sc_q[Lat-2][2]), .lin_o(lin)
  );

  assign out_o.valid = valid_q[Lat-1];
  assign out_o.m00   = lin[0];
  assign out_o.m01   = lin[1];
  assign out_o.m02   = lin[2];
  assign out_o.m03   = tr_q[Lat-1][0];
  assign out_o.m10   = lin[3];
  assign out_o.m11   = lin[4];
  assign out_o.m12   = lin[5];
  assign out_o.m13   = tr_q[Lat-1][1];
  assign out_o.m20   = lin[6];
  assign out_o.m21   = lin[7];
  assign out_o.m22   = lin[8];
  assign out_o.m23   = tr_q[Lat-1][2];

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(valid_q))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> valid_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_reach_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && valid_q[Lat-2]) |=> out_o.valid)
    else $error("transaction lost before the output register");
`endif

endmodule

// ----- dv/tb_etm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_etm_if
// Testbench channel types: one input transaction and one matrix result.
// ----------------------------------------------------------------------------
package tb_etm_pkg;

  typedef struct {
    logic signed [31:0] tx, ty, tz;
    logic signed [15:0] ax, ay, az;
    logic signed [15:0] sx, sy, sz;
  } pose_t;

  typedef struct {
    logic signed [23:0] lin [9];
    logic signed [31:0] trn [3];
  } matrix_t;

endpackage

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pose transactions into euler_trs_model_matrix under random idling
// and a long output hold-off, predicts each matrix with a bit-exact CORDIC
// and fixed-point product model, and compares every result in order.
// ----------------------------------------------------------------------------
module testbench;
  import etm_pkg::*;
  import tb_etm_pkg::*;

  localparam int Stages  = 16;
  localparam int Latency = Stages + 4;

  logic clk_i;
  logic rst_ni;

  etm_in_if  in_ch ();
  etm_out_if out_ch ();

  euler_trs_model_matrix #(.CORDIC_STAGES(Stages)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  matrix_t pending_matrices[$];
  int      fail_count;
  int      src_idle_pct;
  int      snk_idle_pct;
  int      hold_cycles;
  logic    hold_req;
  logic    stim_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void sin_cos(logic signed [15:0] ang, output longint s,
                                  output longint c);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'(ang) * 131072;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426;
      flip = 1;
    end
    for (int i = 0; i < Stages && i < AtanLen; i++) begin
      dx = shr(y, i);
      dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(i));
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic logic signed [23:0] scale_entry(longint r, logic signed [15:0] k);
    longint v;
    v = (r * longint'(k) + (64'sd1 <<< 21)) >>> 22;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  function automatic matrix_t model_matrix(pose_t p);
    longint  snx, csx, sny, csy, snz, csz;
    longint  r[9];
    matrix_t m;
    sin_cos(p.ax, snx, csx);
    sin_cos(p.ay, sny, csy);
    sin_cos(p.az, snz, csz);
    r[0] = mul_q30(csz, csy);
    r[1] = mul_q30(mul_q30(csz, sny), snx) + mul_q30(snz, csx);
    r[2] = mul_q30(snz, snx) - mul_q30(mul_q30(csz, sny), csx);
    r[3] = -mul_q30(snz, csy);
    r[4] = mul_q30(csz, csx) - mul_q30(mul_q30(snz, sny), snx);
    r[5] = mul_q30(mul_q30(snz, sny), csx) + mul_q30(csz, snx);
    r[6] = sny;
    r[7] = -mul_q30(csy, snx);
    r[8] = mul_q30(csy, csx);
    for (int k = 0; k < 9; k++)
      m.lin[k] = scale_entry(r[k], (k % 3 == 0) ? p.sx : (k % 3 == 1) ? p.sy : p.sz);
    m.trn[0] = p.tx;
    m.trn[1] = p.ty;
    m.trn[2] = p.tz;
    return m;
  endfunction

  function automatic pose_t rand_pose();
    pose_t p;
    p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
    p.ax = 16'($urandom); p.ay = 16'($urandom); p.az = 16'($urandom);
    if ($urandom_range(3) != 0) begin
      p.sx = 16'($urandom_range(1024) - 512);
      p.sy = 16'($urandom_range(1024) - 512);
      p.sz = 16'($urandom_range(1024) - 512);
    end else begin
      p.sx = 16'($urandom); p.sy = 16'($urandom); p.sz = 16'($urandom);
    end
    return p;
  endfunction

  task automatic send_pose(pose_t p);
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid       <= 1'b1;
    in_ch.translate_x <= p.tx; in_ch.translate_y <= p.ty; in_ch.translate_z <= p.tz;
    in_ch.angle_x     <= p.ax; in_ch.angle_y     <= p.ay; in_ch.angle_z     <= p.az;
    in_ch.scale_x     <= p.sx; in_ch.scale_y     <= p.sy; in_ch.scale_z     <= p.sz;
    pending_matrices.insert(pending_matrices.size(), model_matrix(p));
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // directed rows: translation extremes, angle extremes, zero/negative/huge scale
  localparam int DirRows = 14;
  logic [191:0] pose_rows [DirRows] = '{
    {32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0100, 16'h0100},
    {32'h7fffffff, 32'h80000000, 32'hffffffff, 16'h0, 16'h0, 16'h0,
     16'h0100, 16'h0100, 16'h0100},
    {32'h1, 32'h2, 32'h3, 16'h7fff, 16'h8000, 16'h0, 16'h0100, 16'h0100, 16'h0100},
    {32'h0, 32'h0, 32'h0, 16'h8000, 16'h7fff, 16'h7fff, 16'h0100, 16'h0100, 16'h0100},
    {32'h0, 32'h0, 32'h0, 16'd12868, 16'd12868, 16'd12868, 16'h0100, 16'h0100, 16'h0100},
    {32'h0, 32'h0, 32'h0, -16'sd12868, 16'd12869, -16'sd12869, 16'h0100, 16'h0100, 16'h0100},
    {32'h0, 32'h0, 32'h0, 16'd25736, -16'sd25736, 16'd25737, 16'h0100, 16'h0100, 16'h0100},
    {32'h0, 32'h0, 32'h0, 16'h1000, 16'h2000, 16'h3000, 16'h0, 16'h0, 16'h0},
    {32'h0, 32'h0, 32'h0, 16'h1000, 16'h2000, 16'h3000, 16'hff00, 16'h8000, 16'hffff},
    {32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h7fff, 16'h7fff},
    {32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h8000, 16'h8000},
    {32'h0, 32'h0, 32'h0, 16'h0600, 16'hfa00, 16'h0300, 16'h7fff, 16'h8000, 16'h4000},
    {32'h55555555, 32'haaaaaaaa, 32'h12345678, 16'h5555, 16'haaaa, 16'h0001,
     16'h5555, 16'haaaa, 16'h0001},
    {32'h0, 32'h0, 32'h0, 16'hffff, 16'h0001, 16'hfffe, 16'h0001, 16'hffff, 16'h0002}
  };

  initial begin
    pose_t   p;
    matrix_t unit_m;
    int      n;
    in_ch.valid = 1'b0;
    {in_ch.translate_x, in_ch.translate_y, in_ch.translate_z} = '0;
    {in_ch.angle_x, in_ch.angle_y, in_ch.angle_z} = '0;
    {in_ch.scale_x, in_ch.scale_y, in_ch.scale_z} = '0;
    src_idle_pct = 35;
    snk_idle_pct = 64;
    hold_req  = 1'b0;
    stim_done = 1'b0;
    fail_count = 0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < DirRows; i++) begin
      {p.tx, p.ty, p.tz, p.ax, p.ay, p.az, p.sx, p.sy, p.sz} = pose_rows[i];
      if (i == 7) begin
        // zero scale collapses every linear entry to 0
        unit_m = model_matrix(p);
        if (unit_m.lin[1] !== 24'sd0 || unit_m.lin[3] !== 24'sd0 || unit_m.trn[0] !== 0) begin
          $display("%0t: predictor zero-scale row expected 0, got %0d %0d %0d",
                   $time, unit_m.lin[1], unit_m.lin[3], unit_m.trn[0]);
          fail_count++;
        end
      end
      send_pose(p);
    end
    for (n = 0; n < 640; n++) begin
      if (n == 60) hold_req = 1'b1;
      if (n == 210) begin src_idle_pct = 64; snk_idle_pct = 35; end
      if (n == 430) begin src_idle_pct = 0; snk_idle_pct = 0; end
      send_pose(rand_pose());
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    out_ch.ready = 1'b0;
    hold_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && hold_cycles < 200) begin
        hold_cycles++;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    matrix_t want;
    logic signed [23:0] got_lin [9];
    logic signed [31:0] got_trn [3];
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got_lin = '{out_ch.m00, out_ch.m01, out_ch.m02, out_ch.m10, out_ch.m11,
                  out_ch.m12, out_ch.m20, out_ch.m21, out_ch.m22};
      got_trn = '{out_ch.m03, out_ch.m13, out_ch.m23};
      if (pending_matrices.size() == 0) begin
        $display("%0t: unexpected result, expected none, got m00=%0d", $time, got_lin[0]);
        fail_count++;
      end else begin
        want = pending_matrices.pop_front();
        for (int k = 0; k < 9; k++)
          if (got_lin[k] !== want.lin[k]) begin
            $display("%0t: m%0d%0d expected %0d, got %0d", $time, k / 3, k % 3,
                     want.lin[k], got_lin[k]);
            fail_count++;
          end
        for (int k = 0; k < 3; k++)
          if (got_trn[k] !== want.trn[k]) begin
            $display("%0t: m%0d3 expected %0d, got %0d", $time, k, want.trn[k], got_trn[k]);
            fail_count++;
          end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_matrices.size() != 0) @(posedge clk_i);
    repeat (Latency * 3) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("euler_trs_model_matrix: match");
    end else begin
      $display("euler_trs_model_matrix: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("euler_trs_model_matrix: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/etm_pkg.sv
rtl/etm_in_if.sv
rtl/etm_out_if.sv
rtl/etm_cordic.sv
rtl/etm_rotmat.sv
rtl/etm_scale.sv
rtl/euler_trs_model_matrix.sv
dv/tb_etm_if.sv
dv/testbench.sv
